// File: hdl/timed_event_queue_core_macros.svh
// Assertion macros for the timed event queue core.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef TIMED_EVENT_QUEUE_CORE_MACROS_SVH
`define TIMED_EVENT_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("teq assertion failed");
`define TEQ_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("teq assertion failed");
`else
`define TEQ_ASSERT_IMP(label, clk, rst, a, b)
`define TEQ_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: hdl/teq_pkg.sv
// Shared types, constants and helpers of the timed event queue.
// No dependencies.
package teq_pkg;
   localparam int CAPACITY     = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int RCW = $clog2(RESULT_LIMIT + 1);

   localparam logic [2:0] OP_INS_NET  = 3'd0;
   localparam logic [2:0] OP_INS_TASK = 3'd1;
   localparam logic [2:0] OP_POP      = 3'd2;
   localparam logic [2:0] OP_PEEK     = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NO_NET = 2'd2;
   localparam logic [1:0] ST_NONE   = 2'd3;

   localparam logic [2:0] VALUE_BLANK = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] event_time;
      logic [15:0] net_id;
      logic [15:0] reg_id;
      logic [1:0]  logic_level;
      logic [7:0]  task_code;
      logic [15:0] args_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        is_task;
      logic [63:0] out_time;
      logic [15:0] out_net;
      logic [15:0] out_reg;
      logic [2:0]  out_value;
      logic [7:0]  out_task;
      logic [15:0] out_args;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] ev_time;
      logic        is_task;
      logic [15:0] net_id;
      logic [15:0] reg_id;
      logic [2:0]  value;
      logic [7:0]  task_code;
      logic [15:0] args;
   } entry_type;

   typedef struct packed {
      logic       load_req;
      logic       ins_read;
      logic       ins_shift;
      logic       ins_write;
      logic       idx_read;
      logic       idx_inc;
      logic       pend_load;
      logic       emit_pend;
      logic       emit_last;
      logic       emit_status;
      logic [1:0] status;
      logic       pop_commit;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       no_net;
      logic       full;
      logic       empty;
      logic       k_zero;
      logic       ins_gt;
      logic       idx_end;
      logic       scan_lt;
      logic       run_match;
      logic       pend_valid;
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_INS_RD, S_INS_CMP, S_PK_RD, S_PK_CMP, S_EM_RD, S_EM_CHK
   } state_type;

   // Map a head-relative sum back into the table.
   function automatic logic [AW-1:0] teq_wrap(input logic [CW:0] sum);
      logic [CW:0] adj;
      adj = (sum >= (CW+1)'(CAPACITY)) ? sum - (CW+1)'(CAPACITY) : sum;
      return adj[AW-1:0];
   endfunction
endpackage

// File: hdl/teq_ctrl.sv
// Controller state machine of the timed event queue.
// Depends on teq_pkg; drives commands into teq_dpath.
module teq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  teq_pkg::stat_type stat,
   output teq_pkg::cmd_type  cmd
);
   import teq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            case (stat.op)
               OP_INS_NET, OP_INS_TASK: begin
                  if (stat.op == OP_INS_NET && stat.no_net) begin
                     cmd.emit_status = 1'b1;
                     cmd.status      = ST_NO_NET;
                  end else if (stat.full) begin
                     cmd.emit_status = 1'b1;
                     cmd.status      = ST_FULL;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.emit_status = 1'b1;
                     cmd.status      = ST_NONE;
                  end else begin
                     state_in = S_EM_RD;
                  end
               end
               OP_PEEK: state_in = S_PK_RD;
               OP_CLEAR: begin
                  cmd.clear       = 1'b1;
                  cmd.emit_status = 1'b1;
                  cmd.status      = ST_OK;
               end
               default: begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = ST_OK;
               end
            endcase
         end
         // walk down from the tail, moving later entries up one slot
         S_INS_RD: begin
            if (stat.k_zero) begin
               cmd.ins_write   = 1'b1;
               cmd.emit_status = 1'b1;
               cmd.status      = ST_OK;
               state_in        = S_IDLE;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (stat.ins_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_RD;
            end else begin
               cmd.ins_write   = 1'b1;
               cmd.emit_status = 1'b1;
               cmd.status      = ST_OK;
               state_in        = S_IDLE;
            end
         end
         S_PK_RD: begin
            if (stat.idx_end) begin
               cmd.emit_status = 1'b1;
               cmd.status      = ST_NONE;
               state_in        = S_IDLE;
            end else begin
               cmd.idx_read = 1'b1;
               state_in     = S_PK_CMP;
            end
         end
         S_PK_CMP: begin
            if (stat.scan_lt) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_PK_RD;
            end else begin
               state_in = S_EM_CHK;
            end
         end
         S_EM_RD: begin
            if (stat.idx_end) begin
               state_in = S_IDLE;
               if (stat.pend_valid) begin
                  cmd.emit_pend  = 1'b1;
                  cmd.emit_last  = 1'b1;
                  cmd.pop_commit = (stat.op == OP_POP);
               end else begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = ST_NONE;
               end
            end else begin
               cmd.idx_read = 1'b1;
               state_in     = S_EM_CHK;
            end
         end
         // the held item goes out once the next entry shows whether it ends the run
         S_EM_CHK: begin
            if (stat.run_match) begin
               cmd.pend_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               cmd.emit_pend = stat.pend_valid;
               state_in      = S_EM_RD;
            end else begin
               state_in = S_IDLE;
               if (stat.pend_valid) begin
                  cmd.emit_pend  = 1'b1;
                  cmd.emit_last  = 1'b1;
                  cmd.pop_commit = (stat.op == OP_POP);
               end else begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = ST_NONE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// File: hdl/teq_dpath.sv
// Datapath of the timed event queue: circular entry memory, pointers, output register.
// Depends on teq_pkg; commanded by teq_ctrl.
module teq_dpath (
   input  logic              clock,
   input  logic              reset,
   input  teq_pkg::req_type  req_item,
   input  teq_pkg::cmd_type  cmd,
   output teq_pkg::stat_type stat,
   output logic              rsp_strobe,
   output teq_pkg::rsp_type  rsp_item
);
   import teq_pkg::*;

   entry_type   mem [CAPACITY];
   req_type     req_ff;
   entry_type   rd_ff, pend_ff, new_rec;
   logic [AW-1:0]  head_ff;
   logic [CW-1:0]  fill_ff, k_ff, i_ff;
   logic [RCW-1:0] run_cnt_ff;
   logic [63:0]    tt_ff;
   logic           pend_v_ff, rsp_v_ff;
   rsp_type        rsp_ff, status_rsp;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [CW-1:0]  k_dec;

   assign k_dec   = k_ff - CW'(1);
   assign wr_addr = teq_wrap((CW+1)'(head_ff) + (CW+1)'(k_ff));
   assign rd_addr = cmd.ins_read ? teq_wrap((CW+1)'(head_ff) + (CW+1)'(k_dec))
                                 : teq_wrap((CW+1)'(head_ff) + (CW+1)'(i_ff));

   always_comb begin
      new_rec         = '0;
      new_rec.ev_time = req_ff.event_time;
      if (req_ff.op == OP_INS_TASK) begin
         new_rec.is_task   = 1'b1;
         new_rec.value     = VALUE_BLANK;
         new_rec.task_code = req_ff.task_code;
         new_rec.args      = req_ff.args_handle;
      end else begin
         new_rec.net_id = req_ff.net_id;
         new_rec.reg_id = req_ff.reg_id;
         new_rec.value  = {1'b0, req_ff.logic_level};
      end
   end

   always_comb begin
      status_rsp        = '0;
      status_rsp.status = cmd.status;
      status_rsp.last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_shift) begin
         mem[wr_addr] <= rd_ff;
      end else if (cmd.ins_write) begin
         mem[wr_addr] <= new_rec;
      end
      if (cmd.ins_read || cmd.idx_read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
         tt_ff  <= req_item.event_time;
         k_ff   <= fill_ff;
         i_ff   <= '0;
      end
      if (cmd.ins_shift) begin
         k_ff <= k_dec;
      end
      if (cmd.idx_inc) begin
         i_ff <= i_ff + CW'(1);
      end
      if (cmd.pend_load) begin
         pend_ff <= rd_ff;
         if (!pend_v_ff) begin
            tt_ff <= rd_ff.ev_time;
         end
      end
      if (cmd.emit_pend) begin
         rsp_ff.status    <= ST_OK;
         rsp_ff.is_task   <= pend_ff.is_task;
         rsp_ff.out_time  <= pend_ff.ev_time;
         rsp_ff.out_net   <= pend_ff.net_id;
         rsp_ff.out_reg   <= pend_ff.reg_id;
         rsp_ff.out_value <= pend_ff.value;
         rsp_ff.out_task  <= pend_ff.task_code;
         rsp_ff.out_args  <= pend_ff.args;
         rsp_ff.last      <= cmd.emit_last;
      end else if (cmd.emit_status) begin
         rsp_ff <= status_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         fill_ff    <= '0;
         pend_v_ff  <= 1'b0;
         run_cnt_ff <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         rsp_v_ff <= cmd.emit_pend || cmd.emit_status;
         if (cmd.load_req) begin
            pend_v_ff  <= 1'b0;
            run_cnt_ff <= '0;
         end
         if (cmd.pend_load) begin
            pend_v_ff  <= 1'b1;
            run_cnt_ff <= run_cnt_ff + RCW'(1);
         end
         if (cmd.clear) begin
            fill_ff <= '0;
         end else if (cmd.ins_write) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (cmd.pop_commit) begin
            // drop the emitted run from the head
            head_ff <= teq_wrap((CW+1)'(head_ff) + (CW+1)'(i_ff));
            fill_ff <= fill_ff - i_ff;
         end
      end
   end

   always_comb begin
      stat.op         = req_ff.op;
      stat.no_net     = (req_ff.net_id == 16'd0);
      stat.full       = (fill_ff == CW'(CAPACITY));
      stat.empty      = (fill_ff == '0);
      stat.k_zero     = (k_ff == '0);
      stat.ins_gt     = (rd_ff.ev_time > req_ff.event_time);
      stat.idx_end    = (i_ff >= fill_ff);
      stat.scan_lt    = (rd_ff.ev_time < req_ff.event_time);
      stat.run_match  = (((req_ff.op == OP_POP) && !pend_v_ff) || (rd_ff.ev_time == tt_ff))
                        && (run_cnt_ff < RCW'(RESULT_LIMIT));
      stat.pend_valid = pend_v_ff;
   end

   assign rsp_strobe = rsp_v_ff;
   assign rsp_item   = rsp_ff;
endmodule

// File: hdl/timed_event_queue_core.sv
// Timed event queue core: time-ordered table of pending transitions and task entries.
// Depends on teq_pkg, teq_ctrl, teq_dpath and timed_event_queue_core_macros.svh.
//
// Usage: drive req_item and raise start while busy is low; the item is taken at
// that clock edge and busy stays high until its work is done. Results appear on
// rsp_item for one cycle each, marked by rsp_strobe; last marks the final result
// of an item. The receiver cannot stall: every strobe must be taken.
// Operations: insert transition, insert task, pop earliest run, peek at a time,
// clear. Inserts and clear give one status result.
// Timing: the table is a circular buffer in a memory with a registered read.
// An insert reads each entry later than the new time and moves it up one
// slot, then writes the new entry. A pop reads the entries of its run in turn;
// a peek first scans the earlier entries, then reads the run at its time. The
// final result of an item is strobed in the same cycle that busy falls.
// Reset: synchronous, active high; empties the table and returns to idle.
module timed_event_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  teq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output teq_pkg::rsp_type rsp_item
);
   import teq_pkg::*;
   `include "timed_event_queue_core_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   teq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   teq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   `TEQ_ASSERT_IMP(a_err_is_last, clock, reset, rsp_strobe && rsp_item.status != ST_OK, rsp_item.last)
   `TEQ_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `TEQ_ASSERT_IMP(a_more_busy, clock, reset, rsp_strobe && !rsp_item.last, busy)
   `TEQ_ASSERT_IMP(a_fill_sane, clock, reset, stat.full, !stat.empty)
endmodule
